// ----- sv/skt_pkg.sv -----
// Package for the sorted key table: request and response transaction types,
// request and status codes, and the record type handed between table cells.
// Used by skt_cell and sorted_key_table_top; depends on nothing else.
`default_nettype none

package skt_pkg;

	// Default number of table cells.
	localparam int SKT_CAPACITY = 64;

	// Request codes.
	localparam logic [1:0] REQ_ADD = 2'd0;
	localparam logic [1:0] REQ_DEL = 2'd1;
	localparam logic [1:0] REQ_REP = 2'd2;
	localparam logic [1:0] REQ_GET = 2'd3;

	// Status codes.
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_DUP  = 2'd1;
	localparam logic [1:0] ST_MISS = 2'd2;
	localparam logic [1:0] ST_FULL = 2'd3;

	// Request transaction.
	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] key;
		logic [63:0] payload_in;
	} req_t;

	// Response transaction.
	typedef struct packed {
		logic [1:0]  status;
		logic [6:0]  position;
		logic [63:0] payload_out;
		logic [6:0]  entry_count;
	} rsp_t;

	// One stored record.
	typedef struct packed {
		logic [31:0] key;
		logic [63:0] payload;
	} rec_t;

	// Update command broadcast to every cell.
	typedef struct packed {
		logic ins;
		logic del;
		logic rep;
		rec_t rec;
	} cell_cmd_t;

endpackage

`default_nettype wire

// ----- sv/skt_cell.sv -----
// One cell of the sorted key table: holds a record, compares it against the
// search key and shifts records to or from its neighbors on insert and delete.
// Depends on skt_pkg.
`default_nettype none

module skt_cell
	import skt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        capture,
	input  wire logic [31:0] search_key,
	input  wire logic        valid,
	input  wire cell_cmd_t   cmd,
	input  wire logic        prev_less,
	input  wire rec_t        prev_rec,
	input  wire rec_t        next_rec,
	output rec_t             rec,
	output logic             less,
	output logic             eq
);

	rec_t rec_q;
	logic less_s1;
	logic eq_s1;

	assign rec  = rec_q;
	assign less = less_s1;
	assign eq   = eq_s1;

	// Capture the comparison flags when a request is accepted.
	always_ff @(posedge clk) begin
		if (capture) begin
			less_s1 <= valid && (rec_q.key < search_key);
			eq_s1   <= valid && (rec_q.key == search_key);
		end
	end

	// Record update: cells from the insertion point shift up or down, or replace.
	always_ff @(posedge clk) begin
		if (cmd.ins && !less_s1) begin
			rec_q <= prev_less ? cmd.rec : prev_rec;
		end else if (cmd.del && !less_s1) begin
			rec_q <= next_rec;
		end else if (cmd.rep && eq_s1) begin
			rec_q.payload <= cmd.rec.payload;
		end
	end

endmodule

`default_nettype wire

// ----- sv/sorted_key_table_top.sv -----
// Sorted key table: records kept in ascending unique key order across a row
// of cells. Each request accepted on the in channel (valid/ready, req_t
// payload) yields exactly one response transaction on the out channel
// (valid/ready, rsp_t payload).
// A request is accepted when every cell registers the comparison of its
// key with the request key. The response is then formed from those flags
// and the cells shift or update; the response register is loaded at that
// same edge. The block takes no new request until the response to the
// previous one has been registered.
// The response register parts the two channels: a new request is taken
// while a response waits. If the receiver stalls with a response pending,
// the following request waits with its flags held, and the table is not
// changed until its response can be registered.
// Reset clears the entry count and the handshake state; the cell contents
// are left as they are and are never read at or above the count.
// Depends on skt_pkg and skt_cell.
`default_nettype none

module sorted_key_table_top
	import skt_pkg::*;
#(
	parameter int CAPACITY = SKT_CAPACITY
)(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire req_t in_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output rsp_t      out_data
);

	localparam int IW = $clog2(CAPACITY + 1);
	localparam int PW = (IW > 7) ? IW : 7;

	logic            busy_q;
	logic            out_valid_q;
	rsp_t            out_q;
	req_t            req_s1;
	logic [IW-1:0]   count_q;

	logic            accept;
	logic            commit;
	logic            hit;
	logic            full;
	cell_cmd_t       cmd;
	rsp_t            rsp;
	logic [PW-1:0]   pos;
	logic [PW-1:0]   count_next;
	logic [63:0]     hit_payload;

	rec_t            rec_arr   [CAPACITY];
	logic [CAPACITY-1:0] less_vec;
	logic [CAPACITY-1:0] eq_vec;
	logic [CAPACITY-1:0] prev_less_vec;

	assign accept    = in_valid && in_ready;
	assign in_ready  = !busy_q;
	assign commit    = busy_q && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Row of cells with neighbor links.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic cell_valid;
		rec_t prev_rec;
		rec_t next_rec;

		assign cell_valid = (IW'(i) < count_q);
		assign prev_less_vec[i] = (i == 0) ? 1'b1 : less_vec[(i == 0) ? 0 : i - 1];
		assign prev_rec = rec_arr[(i == 0) ? 0 : i - 1];
		assign next_rec = rec_arr[(i == CAPACITY - 1) ? i : i + 1];

		skt_cell u_cell (
			.clk        (clk),
			.capture    (accept),
			.search_key (in_data.key),
			.valid      (cell_valid),
			.cmd        (cmd),
			.prev_less  (prev_less_vec[i]),
			.prev_rec   (prev_rec),
			.next_rec   (next_rec),
			.rec        (rec_arr[i]),
			.less       (less_vec[i]),
			.eq         (eq_vec[i])
		);
	end

	assign hit  = |eq_vec;
	assign full = (count_q == IW'(CAPACITY));

	// Command to the cells, issued only when the response can be registered.
	always_comb begin
		cmd.ins         = commit && (req_s1.req_type == REQ_ADD) && !hit && !full;
		cmd.del         = commit && (req_s1.req_type == REQ_DEL) && hit;
		cmd.rep         = commit && (req_s1.req_type == REQ_REP) && hit;
		cmd.rec.key     = req_s1.key;
		cmd.rec.payload = req_s1.payload_in;
	end

	// Insertion point: first cell not below the key, and its stored payload.
	always_comb begin
		pos         = '0;
		hit_payload = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (!less_vec[i] && prev_less_vec[i]) begin
				pos = pos | PW'(i + 1);
			end
			if (eq_vec[i]) begin
				hit_payload = hit_payload | rec_arr[i].payload;
			end
		end
	end

	// Entry count after the request.
	always_comb begin
		count_next = PW'(count_q);
		if (cmd.ins) begin
			count_next = PW'(count_q) + PW'(1);
		end else if (cmd.del) begin
			count_next = PW'(count_q) - PW'(1);
		end
	end

	// Response formation.
	always_comb begin
		rsp.status      = ST_OK;
		rsp.position    = pos[6:0];
		rsp.payload_out = '0;
		rsp.entry_count = count_next[6:0];
		case (req_s1.req_type)
			REQ_ADD: begin
				if (hit) begin
					rsp.status = ST_DUP;
				end else if (full) begin
					rsp.status   = ST_FULL;
					rsp.position = '0;
				end
			end
			REQ_GET: begin
				if (!hit) begin
					rsp.status   = ST_MISS;
					rsp.position = '0;
				end else begin
					rsp.payload_out = hit_payload;
				end
			end
			default: begin
				if (!hit) begin
					rsp.status   = ST_MISS;
					rsp.position = '0;
				end
			end
		endcase
	end

	// Control state: busy flag, entry count and response handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (commit) begin
				busy_q <= 1'b0;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
				count_q     <= count_next[IW-1:0];
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request and response payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= in_data;
		end
		if (commit) begin
			out_q <= rsp;
		end
	end

	// Keys are unique, so at most one cell can match the request key.
	a_unique_hit: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> $onehot0(eq_vec))
		else $error("more than one cell matches the request key");

	// The entry count never exceeds the table size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= IW'(CAPACITY))
		else $error("entry count exceeds capacity");

	// A new response only appears after a request was in progress.
	a_rsp_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(busy_q))
		else $error("response without a request in progress");

	// The count changes only when a request completes.
	a_count_commit: assert property (@(posedge clk) disable iff (!arst_n)
		!commit |=> $stable(count_q))
		else $error("entry count changed without a completed request");

endmodule

`default_nettype wire
